// File: rtl/core/hrsp_pkg.sv
// Package for the HTTP request stream parser: item and state types, phase and
// token codes, delimiter bytes and the match text tables.
// No dependencies.
package hrsp_pkg;

	// headers recorded at most
	localparam int unsigned HEADER_LIMIT = 32;

	// field widths
	localparam int unsigned LEN_W   = 31;
	localparam int unsigned TOTAL_W = 6;
	localparam int unsigned SLOT_W  = 5;
	localparam int unsigned POS_W   = 4;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [POS_W-1:0] KEY_LEN = POS_W'(14);
	localparam logic [POS_W-1:0] VER_LEN = POS_W'(8);
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// value reader sub-states kept in the match position
	localparam logic [POS_W-1:0] VAL_LEAD   = POS_W'(0);
	localparam logic [POS_W-1:0] VAL_DIGITS = POS_W'(1);
	localparam logic [POS_W-1:0] VAL_STOP   = POS_W'(2);

	// delimiter and special bytes
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [3:0] {
		PH_METHOD     = 4'd0,
		PH_URI        = 4'd1,
		PH_VERSION    = 4'd2,
		PH_VERSION_LF = 4'd3,
		PH_KEY        = 4'd4,
		PH_KEY_SP     = 4'd5,
		PH_VALUE      = 4'd6,
		PH_VALUE_LF   = 4'd7,
		PH_END_LF     = 4'd8,
		PH_BODY       = 4'd9,
		PH_ERROR      = 4'd10
	} phase_t;

	// token kind codes
	localparam logic [2:0] TK_METHOD  = 3'd0;
	localparam logic [2:0] TK_URI     = 3'd1;
	localparam logic [2:0] TK_VERSION = 3'd2;
	localparam logic [2:0] TK_KEY     = 3'd3;
	localparam logic [2:0] TK_VALUE   = 3'd4;
	localparam logic [2:0] TK_DELIM   = 3'd5;
	localparam logic [2:0] TK_BODY    = 3'd6;
	localparam logic [2:0] TK_IGNORED = 3'd7;

	// parse status codes
	localparam logic [1:0] ST_INCOMPLETE = 2'd0;
	localparam logic [1:0] ST_COMPLETE   = 2'd1;
	localparam logic [1:0] ST_MALFORMED  = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         token_kind;
		logic [SLOT_W-1:0]  header_slot;
		logic [1:0]         parse_status;
		logic [LEN_W-1:0]   body_length;
		logic [TOTAL_W-1:0] header_total;
		logic               final_flag;
	} out_item_t;

	typedef struct packed {
		phase_t             phase;
		logic [POS_W-1:0]   match_position;
		logic               key_still_matches;
		logic [LEN_W-1:0]   length_accumulator;
		logic               length_found;
		logic [TOTAL_W-1:0] headers_seen;
		logic [LEN_W-1:0]   body_remaining;
		logic               malformed_seen;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:              PH_METHOD,
		match_position:     '0,
		key_still_matches:  1'b1,
		length_accumulator: '0,
		length_found:       1'b0,
		headers_seen:       '0,
		body_remaining:     '0,
		malformed_seen:     1'b0
	};

	// "Content-Length", one character per position
	function automatic logic [7:0] key_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h4C; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "HTTP/1.1", one character per position
	function automatic logic [7:0] ver_char(input logic [POS_W-1:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = 8'h48; // H
			4'd1:    c = 8'h54; // T
			4'd2:    c = 8'h54; // T
			4'd3:    c = 8'h50; // P
			4'd4:    c = 8'h2F; // /
			4'd5:    c = 8'h31; // 1
			4'd6:    c = 8'h2E; // .
			4'd7:    c = 8'h31; // 1
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/http_request_stream_parser.sv
// HTTP request stream parser top level: input register, parser state,
// result register and the valid/ready handshakes.
// Depends on hrsp_pkg and hrsp_step.
//
// Usage: request bytes enter on the byte channel (byte_valid, byte_ready,
// byte_item), one byte per item, with end_of_data set on the last byte of a
// request. Every byte yields exactly one result item on the tag channel
// (tag_valid, tag_ready, tag_item): the token kind, header slot, running
// status, Content-Length value and header count as of that byte.
// A byte is captured in the input register and the parse step then writes the
// result register, which drives tag_valid. Throughput is one byte per cycle
// while results are taken; the per-byte phase machine updates its state in a
// single step, so a byte can follow in every cycle that the result moves on.
// Reset (arst_n low) clears both pipeline valids and puts the parser in the
// method phase with no headers and no length. A result with end_of_data set
// is final and the parser returns to that same state for the next request.
// When tag_ready is low the result register holds and the input register
// fills; byte_ready then drops until the result is taken. Nothing is dropped.
module http_request_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  hrsp_pkg::in_item_t byte_item,
	output logic               tag_valid,
	input  logic               tag_ready,
	output hrsp_pkg::out_item_t tag_item
);
	import hrsp_pkg::*;

	logic         valid_s1;
	in_item_t     item_s1;
	parse_state_t st_q;
	parse_state_t st_next;
	out_item_t    result;
	logic         res_valid_q;
	out_item_t    res_q;
	logic         advance;

	// result register frees when empty or taken
	assign advance    = !res_valid_q || tag_ready;
	assign byte_ready = !valid_s1 || advance;
	assign tag_valid  = res_valid_q;
	assign tag_item   = res_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid)
			item_s1 <= byte_item;
	end

	// parse step
	hrsp_step u_step (
		.st      (st_q),
		.item    (item_s1),
		.st_next (st_next),
		.result  (result)
	);

	// parser state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RESET;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1)
				st_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_q <= result;
	end

	// malformed results carry only ignored tokens
	a_malformed_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.parse_status == ST_MALFORMED |-> res_q.token_kind == TK_IGNORED)
		else $error("malformed status with a non-ignored token");

	// header slot only on key and value bytes
	a_slot_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.header_slot != '0 |->
			res_q.token_kind == TK_KEY || res_q.token_kind == TK_VALUE)
		else $error("header slot set outside key or value");

	// header count never passes the limit
	a_header_limit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.headers_seen <= TOTAL_W'(HEADER_LIMIT))
		else $error("header count above limit");

	// end of data returns the parser to its start state
	a_eod_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 && item_s1.end_of_data |=>
			st_q.phase == PH_METHOD && !st_q.malformed_seen && st_q.headers_seen == '0)
		else $error("parser not reset after end of data");

	// state moves only when a byte is parsed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(st_q))
		else $error("parser state changed without a byte");

endmodule

// File: rtl/core/hrsp_step.sv
// Per-byte parse step: from the current parser state and one received byte,
// the next state and the tagged result item.
// Depends on hrsp_pkg.
module hrsp_step (
	input  hrsp_pkg::parse_state_t st,
	input  hrsp_pkg::in_item_t     item,
	output hrsp_pkg::parse_state_t st_next,
	output hrsp_pkg::out_item_t    result
);
	import hrsp_pkg::*;

	logic [7:0]         b;
	logic               crlf;
	logic               in_limit;
	logic [SLOT_W-1:0]  cur_slot;
	logic [POS_W-1:0]   pos_inc;
	logic               key_miss;
	logic               ver_miss;
	logic               take;
	logic               is_space;
	logic               is_digit;
	logic [LEN_W+3:0]   acc_next;
	logic [2:0]         kind;
	logic [SLOT_W-1:0]  slot;
	logic               fail;
	parse_state_t       nx;

	// byte classes and shared match helpers
	always_comb begin
		b        = item.data_byte;
		crlf     = (b == CH_CR) || (b == CH_LF);
		in_limit = st.headers_seen < TOTAL_W'(HEADER_LIMIT);
		cur_slot = (st.headers_seen > TOTAL_W'(31)) ? SLOT_W'(31) : st.headers_seen[SLOT_W-1:0];
		pos_inc  = (st.match_position == POS_MAX) ? POS_MAX : st.match_position + POS_W'(1);
		key_miss = (st.match_position >= KEY_LEN) || (b != key_char(st.match_position));
		ver_miss = (st.match_position >= VER_LEN) || (b != ver_char(st.match_position));
		take     = st.key_still_matches && (st.match_position == KEY_LEN) &&
			!st.length_found && in_limit;
		is_space = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
		is_digit = (b >= CH_0) && (b <= CH_9);
		// acc * 10 + digit as shift-add
		acc_next = {1'b0, st.length_accumulator, 3'b000} +
			{3'b000, st.length_accumulator, 1'b0} + (LEN_W+4)'(b - CH_0);
	end

	// phase machine
	always_comb begin
		nx   = st;
		kind = TK_IGNORED;
		slot = '0;
		fail = 1'b0;
		case (st.phase)
			PH_METHOD, PH_URI: begin
				if (b == CH_SP) begin
					kind = TK_DELIM;
					if (st.phase == PH_URI) begin
						nx.match_position    = '0;
						nx.key_still_matches = 1'b1;
						nx.phase             = PH_VERSION;
					end else begin
						nx.phase = PH_URI;
					end
				end else if (crlf) begin
					fail = 1'b1;
				end else begin
					kind = (st.phase == PH_METHOD) ? TK_METHOD : TK_URI;
				end
			end
			PH_VERSION: begin
				if (b == CH_CR) begin
					if (st.key_still_matches && st.match_position == VER_LEN) begin
						kind     = TK_DELIM;
						nx.phase = PH_VERSION_LF;
					end else begin
						fail = 1'b1;
					end
				end else if (b == CH_LF) begin
					fail = 1'b1;
				end else begin
					kind              = TK_VERSION;
					nx.match_position = pos_inc;
					if (ver_miss)
						nx.key_still_matches = 1'b0;
				end
			end
			PH_VERSION_LF: begin
				if (b == CH_LF) begin
					kind                 = TK_DELIM;
					nx.phase             = PH_KEY;
					nx.match_position    = '0;
					nx.key_still_matches = 1'b1;
				end else begin
					fail = 1'b1;
				end
			end
			PH_KEY: begin
				if (st.match_position == '0 && b == CH_CR) begin
					kind     = TK_DELIM;
					nx.phase = PH_END_LF;
				end else if (b == CH_COLON) begin
					kind = TK_DELIM;
					if (take) begin
						nx.length_found       = 1'b1;
						nx.length_accumulator = '0;
					end
					nx.key_still_matches = take;
					nx.match_position    = '0;
					nx.phase             = PH_KEY_SP;
				end else if (crlf) begin
					fail = 1'b1;
				end else begin
					if (in_limit) begin
						kind = TK_KEY;
						slot = cur_slot;
					end
					nx.match_position = pos_inc;
					if (key_miss)
						nx.key_still_matches = 1'b0;
				end
			end
			PH_KEY_SP: begin
				if (b == CH_SP) begin
					kind     = TK_DELIM;
					nx.phase = PH_VALUE;
				end else begin
					fail = 1'b1;
				end
			end
			PH_VALUE: begin
				if (b == CH_CR) begin
					kind     = TK_DELIM;
					nx.phase = PH_VALUE_LF;
				end else begin
					if (in_limit) begin
						kind = TK_VALUE;
						slot = cur_slot;
					end
					// decimal reader for the selected header
					if (st.key_still_matches) begin
						if (st.match_position == VAL_LEAD && is_space) begin
							nx.match_position = VAL_LEAD;
						end else if (st.match_position == VAL_LEAD && b == CH_PLUS) begin
							nx.match_position = VAL_DIGITS;
						end else if (st.match_position == VAL_LEAD && b == CH_MINUS) begin
							nx.match_position = VAL_STOP;
						end else if (st.match_position <= VAL_DIGITS && is_digit) begin
							nx.length_accumulator = (acc_next > (LEN_W+4)'(LEN_MAX)) ?
								LEN_MAX : acc_next[LEN_W-1:0];
							nx.match_position = VAL_DIGITS;
						end else begin
							nx.match_position = VAL_STOP;
						end
					end
				end
			end
			PH_VALUE_LF: begin
				if (b == CH_LF) begin
					kind = TK_DELIM;
					if (in_limit)
						nx.headers_seen = st.headers_seen + TOTAL_W'(1);
					nx.phase             = PH_KEY;
					nx.match_position    = '0;
					nx.key_still_matches = 1'b1;
				end else begin
					fail = 1'b1;
				end
			end
			PH_END_LF: begin
				if (b == CH_LF) begin
					kind              = TK_DELIM;
					nx.phase          = PH_BODY;
					nx.body_remaining = st.length_found ? st.length_accumulator : '0;
				end else begin
					fail = 1'b1;
				end
			end
			PH_BODY: begin
				if (st.body_remaining != '0) begin
					kind              = TK_BODY;
					nx.body_remaining = st.body_remaining - LEN_W'(1);
				end
			end
			default: begin
				kind = TK_IGNORED;
			end
		endcase

		if (fail) begin
			nx.malformed_seen = 1'b1;
			nx.phase          = PH_ERROR;
			kind              = TK_IGNORED;
			slot              = '0;
		end
	end

	// result fields from the updated state, then return to reset on end of data
	always_comb begin
		result.token_kind  = kind;
		result.header_slot = slot;
		if (nx.malformed_seen)
			result.parse_status = ST_MALFORMED;
		else if (nx.phase == PH_BODY && nx.body_remaining == '0)
			result.parse_status = ST_COMPLETE;
		else
			result.parse_status = ST_INCOMPLETE;
		result.body_length  = nx.length_found ? nx.length_accumulator : '0;
		result.header_total = nx.headers_seen;
		result.final_flag   = item.end_of_data;
		st_next = item.end_of_data ? STATE_RESET : nx;
	end

endmodule
